### design/rsrc_pkg.sv
// ----------------------------------------------------------------------------
// Ring slot manager package
// Shared sizes, slot table entry layout and window helper function.
// ----------------------------------------------------------------------------
`default_nettype none

package rsrc_pkg;

	localparam int MAX_UNITS  = 4096;
	localparam int HDR_BYTES  = 16;
	localparam int HDR_SHIFT  = $clog2(HDR_BYTES);
	localparam int IDX_W      = $clog2(MAX_UNITS);
	localparam int OFF_W      = 13;
	localparam int ENT_W      = 15;
	localparam int CNT_W      = 32;

	// Slot table entry: payload units, committed flag, wrap marker flag.
	localparam int F_COMMIT = 13;
	localparam int F_WRAP   = 14;

	typedef logic [OFF_W-1:0] off_t;
	typedef logic [ENT_W-1:0] entry_t;

	localparam logic [1:0] ACT_RESERVE = 2'd0;
	localparam logic [1:0] ACT_COMMIT  = 2'd1;
	localparam logic [1:0] ACT_SYNC    = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_ROOM  = 2'd1;
	localparam logic [1:0] ST_TOO_BIG  = 2'd2;
	localparam logic [1:0] ST_REJECTED = 2'd3;

	function automatic logic strictly_within(input off_t c, input off_t lo, input off_t hi);
		logic r;
		begin
			if (lo == hi || c == lo || c == hi) begin
				r = 1'b0;
			end else if (lo > hi) begin
				r = (c > lo) || (c < hi);
			end else begin
				r = (c > lo) && (c < hi);
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

### design/rsrc_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rsrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### design/ring_slot_reserve_commit_manager_unit.sv
// A granted reserve clears each unit of the record in the slot table in turn, and a commit
// that starts a walk reads the records it passes one after another.
// One transaction is worked on at a time; the next is taken in the cycle after its result is
// registered, so the slot table port sets the pace and a held result stalls the input.
// After reset every slot table entry is swept to zero before the first
// input transaction is accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// Ring slot reserve/commit manager
// Reserves, commits and syncs variable-length records in a ring whose
// slot table lives in a synchronous RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_slot_reserve_commit_manager_unit
	import rsrc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [12:0]  cfg_data,      // ring_units
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [55:0]  s_axis_tdata,  // payload_bytes, commit_offset, reader_bottom,
	                                         // reader_top, zero fill
	input  wire logic [1:0]   s_axis_tuser,  // action
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [119:0]      m_axis_tdata,  // slot_offset, commit_count, granted_bottom,
	                                         // granted_top, reservations_seen, drops_seen, fill
	output logic [1:0]        m_axis_tuser   // status
);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_RES    = 4'd2;
	localparam logic [3:0] S_RCLR   = 4'd3;
	localparam logic [3:0] S_CRD    = 4'd4;
	localparam logic [3:0] S_CWR    = 4'd5;
	localparam logic [3:0] S_WRD    = 4'd6;
	localparam logic [3:0] S_WEV    = 4'd7;
	localparam logic [3:0] S_WNX    = 4'd8;
	localparam logic [3:0] S_SYNC   = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	logic [3:0]       state_q;
	off_t             ring_units_q;
	off_t             wb_q, wt_q, rb_q, rt_q;
	logic [CNT_W-1:0] res_cnt_q, drop_cnt_q;
	logic [IDX_W-1:0] idx_q;

	logic [1:0]       act_q;
	logic [15:0]      bytes_q;
	off_t             coff_q, in_rb_q, in_rt_q;
	off_t             req_q, pay_q;
	logic [IDX_W-1:0] slot_q;
	off_t             rslot_q;
	off_t             count_q;
	logic [13:0]      noff_q;

	logic [1:0]       o_status_q;
	off_t             o_slot_q, o_cnt_q, o_gb_q, o_gt_q;
	logic [CNT_W-1:0] o_rs_q, o_ds_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	entry_t           ram_wdata, ram_rdata;

	rsrc_ram #(.WIDTH(ENT_W), .DEPTH(MAX_UNITS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Derived ring size.
	off_t usize, usable;
	always_comb begin
		if (ring_units_q < 13'd3) begin
			usize = 13'd3;
		end else if (ring_units_q > off_t'(MAX_UNITS)) begin
			usize = off_t'(MAX_UNITS);
		end else begin
			usize = ring_units_q;
		end
		usable = usize - 13'd1;
	end

	// Reserve decision.
	logic [16:0]        bsum;
	off_t               pay, req;
	logic signed [15:0] dist_wrap;
	logic               room, fits_direct, fits_wrap;
	logic [13:0]        top_sum;
	always_comb begin
		bsum      = {1'b0, bytes_q} + 17'(HDR_BYTES - 1);
		pay       = off_t'(bsum >> HDR_SHIFT);
		req       = pay + 13'd1;
		dist_wrap = 16'(signed'({3'b0, usable})) - 16'(signed'({3'b0, wt_q}))
		          + 16'(signed'({3'b0, rb_q}));
		if (wt_q == rb_q) begin
			room = 1'b1;
		end else if (wt_q < rb_q) begin
			room = (rb_q - wt_q) > req;
		end else begin
			// A negative distance wraps to a huge unsigned value.
			room = (dist_wrap < 0) || (dist_wrap > 16'(signed'({3'b0, req})));
		end
		top_sum     = {1'b0, wt_q} + {1'b0, req};
		fits_direct = top_sum <= {1'b0, usable};
		fits_wrap   = req < rb_q;
	end

	// Commit walk step on the entry at slot_q.
	logic [13:0] noff;
	logic        nok;
	always_comb begin
		noff = {2'b0, slot_q} + {1'b0, ram_rdata[OFF_W-1:0]} + 14'd1;
		nok  = !(({1'b0, slot_q} <= wt_q) && (noff >= {1'b0, wt_q}))
		       && (noff <= {1'b0, usable}) && (noff < 14'(MAX_UNITS));
	end

	logic [13:0] nxt;
	logic        walk_round;
	always_comb begin
		nxt        = ram_rdata[F_WRAP] ? 14'd0 : noff_q;
		walk_round = ({1'b0, slot_q} < coff_q) && (nxt >= {1'b0, coff_q});
	end

	// Sync check.
	off_t srb, srt;
	logic sbad, sempty;
	always_comb begin
		if (in_rb_q == '0 && in_rt_q == '0) begin
			srb = rb_q;
			srt = rt_q;
		end else begin
			srb = in_rb_q;
			srt = in_rt_q;
		end
		sbad = (in_rb_q > usize) || (in_rt_q > usize)
		     || strictly_within(srb, wb_q, wt_q) || strictly_within(srt, wb_q, wt_q)
		     || (rt_q != srt) || ((rt_q < wb_q) && (srt > wb_q));
		sempty = wt_q == srb;
	end

	// Table port.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_raddr = slot_q;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_RES: begin
				ram_we    = (req <= usable) && room && !fits_direct && fits_wrap
				          && (wt_q < off_t'(MAX_UNITS));
				ram_waddr = wt_q[IDX_W-1:0];
				ram_wdata = entry_t'((1 << F_WRAP) | (1 << F_COMMIT));
			end
			S_RCLR: begin
				ram_we    = 1'b1;
				ram_waddr = rslot_q[IDX_W-1:0] + idx_q;
				ram_wdata = (idx_q == '0) ? entry_t'(pay_q) : '0;
			end
			S_CRD: begin
				ram_raddr = coff_q[IDX_W-1:0];
			end
			S_CWR: begin
				ram_we    = 1'b1;
				ram_waddr = coff_q[IDX_W-1:0];
				ram_wdata = ram_rdata | entry_t'(1 << F_COMMIT);
			end
			S_WEV: begin
				ram_raddr = noff[IDX_W-1:0];
			end
			S_WNX: begin
				ram_raddr = nxt[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			ring_units_q  <= off_t'(MAX_UNITS);
			wb_q          <= '0;
			wt_q          <= '0;
			rb_q          <= '0;
			rt_q          <= '0;
			res_cnt_q     <= '0;
			drop_cnt_q    <= '0;
			idx_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				ring_units_q <= cfg_data;
			end
			// In S_DONE the output valid is handled by the state itself.
			if (m_axis_tvalid && m_axis_tready && state_q != S_DONE) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_W'(MAX_UNITS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						case (s_axis_tuser)
							ACT_RESERVE: state_q <= S_RES;
							ACT_COMMIT:  state_q <= S_CRD;
							ACT_SYNC:    state_q <= S_SYNC;
							default:     state_q <= S_DONE;
						endcase
					end
				end
				S_RES: begin
					res_cnt_q <= res_cnt_q + 1'b1;
					idx_q     <= '0;
					if (req <= usable && room && fits_direct) begin
						wt_q    <= top_sum[OFF_W-1:0];
						state_q <= S_RCLR;
					end else if (req <= usable && room && fits_wrap) begin
						if (wb_q == wt_q) begin
							wb_q <= '0;
						end
						wt_q    <= req;
						state_q <= S_RCLR;
					end else begin
						drop_cnt_q <= drop_cnt_q + 1'b1;
						state_q    <= S_DONE;
					end
				end
				S_RCLR: begin
					idx_q <= idx_q + 1'b1;
					if ({1'b0, idx_q} + 13'd1 == req_q) begin
						state_q <= S_DONE;
					end
				end
				S_CRD: begin
					state_q <= (coff_q >= off_t'(MAX_UNITS)) ? S_DONE : S_CWR;
				end
				S_CWR: begin
					if (coff_q == wb_q && wb_q != wt_q) begin
						state_q <= S_WRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_WRD: begin
					state_q <= S_WEV;
				end
				S_WEV: begin
					if (!ram_rdata[F_COMMIT]) begin
						state_q <= S_DONE;
					end else if (!nok) begin
						wb_q    <= noff[OFF_W-1:0];
						state_q <= S_DONE;
					end else begin
						state_q <= S_WNX;
					end
				end
				S_WNX: begin
					if (walk_round) begin
						wb_q    <= rt_q;
						wt_q    <= rt_q;
						state_q <= S_DONE;
					end else begin
						wb_q    <= nxt[OFF_W-1:0];
						state_q <= (count_q + 13'd1 == off_t'(MAX_UNITS)) ? S_DONE : S_WEV;
					end
				end
				S_SYNC: begin
					if (!sbad) begin
						if (sempty) begin
							rb_q <= '0;
							wb_q <= '0;
							wt_q <= '0;
							rt_q <= '0;
						end else begin
							rb_q <= srb;
							rt_q <= wb_q;
						end
						res_cnt_q  <= '0;
						drop_cnt_q <= '0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item fields, working registers and the result being built.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					act_q      <= s_axis_tuser;
					bytes_q    <= s_axis_tdata[15:0];
					coff_q     <= s_axis_tdata[28:16];
					in_rb_q    <= s_axis_tdata[41:29];
					in_rt_q    <= s_axis_tdata[54:42];
					o_status_q <= ST_OK;
					o_slot_q   <= '0;
					o_cnt_q    <= '0;
					o_gb_q     <= '0;
					o_gt_q     <= '0;
					o_rs_q     <= '0;
					o_ds_q     <= '0;
				end
			end
			S_RES: begin
				req_q   <= req;
				pay_q   <= pay;
				if (req > usable) begin
					o_status_q <= ST_TOO_BIG;
				end else if (room && fits_direct) begin
					rslot_q  <= wt_q;
					o_slot_q <= wt_q;
				end else if (room && fits_wrap) begin
					rslot_q  <= '0;
				end else begin
					o_status_q <= ST_NO_ROOM;
				end
			end
			S_CWR: begin
				slot_q  <= coff_q[IDX_W-1:0];
				count_q <= '0;
			end
			S_WEV: begin
				noff_q <= noff;
				if (ram_rdata[F_COMMIT] && !nok) begin
					o_cnt_q <= count_q + 13'd1;
				end
			end
			S_WNX: begin
				count_q <= count_q + 13'd1;
				o_cnt_q <= count_q + 13'd1;
				slot_q  <= nxt[IDX_W-1:0];
			end
			S_SYNC: begin
				if (sbad) begin
					o_status_q <= ST_REJECTED;
				end else begin
					o_gb_q <= sempty ? '0 : srb;
					o_gt_q <= sempty ? '0 : wb_q;
					o_rs_q <= res_cnt_q;
					o_ds_q <= drop_cnt_q;
				end
			end
			S_DONE: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					m_axis_tuser <= (act_q == ACT_RESERVE || act_q == ACT_SYNC) ? o_status_q
					                                                            : ST_OK;
					m_axis_tdata <= {4'b0, o_ds_q, o_rs_q, o_gt_q, o_gb_q, o_cnt_q, o_slot_q};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### dv/ring_slot_reserve_commit_manager_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring slot reserve/commit manager testbench
// Drives reserve, commit and sync transactions through the input stream.
// Each result is checked against a fixed expectation or against a cycle-free
// predictor of the ring windows, the slot table and the statistics counters.
// The run covers several ring sizes, random back-pressure and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_slot_reserve_commit_manager_unit_tb;
	import rsrc_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 30000000;

	typedef struct packed {
		logic [1:0]  status;
		logic [12:0] slot;
		logic [12:0] count;
		logic [12:0] gbot;
		logic [12:0] gtop;
		logic [31:0] resv;
		logic [31:0] drops;
	} outcome_t;

	typedef struct {
		logic [1:0]  act;
		logic [15:0] bytes;
		logic [12:0] coff;
		logic [12:0] rb;
		logic [12:0] rt;
		bit          typed;
		logic [1:0]  st;
		logic [12:0] slot;
		logic [12:0] cnt;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [12:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [55:0]  s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [119:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	ring_slot_reserve_commit_manager_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// Predictor state.
	int unsigned ring_cfg, wr_bot, wr_top, rd_bot, rd_top, resv_cnt, drop_cnt;
	logic [14:0] slot_tab [MAX_UNITS];

	outcome_t    outcome_q [$];
	int unsigned open_slots [$];
	int unsigned errors, cycles, sent, received, ok_reserves, walks, good_syncs;
	int          hold_cycles;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out with %0d results outstanding", outcome_q.size());
			$display("FAIL");
			$finish;
		end
	end

	function automatic int unsigned eff_units();
		if (ring_cfg < 3) return 3;
		if (ring_cfg > MAX_UNITS) return MAX_UNITS;
		return ring_cfg;
	endfunction

	function automatic logic [14:0] tab_rd(int unsigned i);
		return (i < MAX_UNITS) ? slot_tab[i] : 15'd0;
	endfunction

	function automatic void tab_wr(int unsigned i, logic [14:0] v);
		if (i < MAX_UNITS) slot_tab[i] = v;
	endfunction

	function automatic int unsigned ring_gap(int unsigned usable, int unsigned a, int unsigned b);
		if (a == b) return 0;
		if (a < b) return b - a;
		return usable - a + b;
	endfunction

	function automatic bit between_open(int unsigned c, int unsigned lo, int unsigned hi);
		if (lo == hi || c == lo || c == hi) return 0;
		if (lo > hi) return (c > lo) || (c < hi);
		return (c > lo) && (c < hi);
	endfunction

	function automatic outcome_t reserve_space(int unsigned bytes);
		outcome_t    o;
		int unsigned usable, pay, req, slot;
		logic [1:0]  st;
		o = '0;
		usable = eff_units() - 1;
		pay = (bytes + HDR_BYTES - 1) / HDR_BYTES;
		req = pay + 1;
		slot = 0;
		resv_cnt++;
		st = ST_NO_ROOM;
		if (req > usable) begin
			st = ST_TOO_BIG;
		end else if (ring_gap(usable, wr_top, rd_bot) > req || wr_top == rd_bot) begin
			if (wr_top + req <= usable) begin
				slot = wr_top;
				wr_top = wr_top + req;
				st = ST_OK;
			end else if (req < rd_bot) begin
				// Not enough room before the end: leave a wrap marker and restart at zero.
				tab_wr(wr_top, 15'h6000);
				if (wr_bot == wr_top) wr_bot = 0;
				slot = 0;
				wr_top = req;
				st = ST_OK;
			end
		end
		if (st == ST_OK) begin
			for (int unsigned i = 0; i < req; i++) tab_wr(slot + i, 15'd0);
			tab_wr(slot, 15'(pay & 13'h1FFF));
			ok_reserves++;
		end else begin
			drop_cnt++;
			slot = 0;
		end
		o.status = st;
		o.slot = slot[12:0];
		return o;
	endfunction

	function automatic outcome_t commit_slot(int unsigned start);
		outcome_t    o;
		int unsigned usable, slot, count, nxt_off, nxt;
		logic [14:0] e, ne;
		bit          have, nxt_ok;
		o = '0;
		usable = eff_units() - 1;
		slot = start;
		count = 0;
		have = 1;
		if (start >= MAX_UNITS) return o;
		slot_tab[start][F_COMMIT] = 1'b1;
		if (start == wr_bot && wr_bot != wr_top) begin
			for (int unsigned steps = 0; steps < MAX_UNITS; steps++) begin
				if (!have) break;
				e = tab_rd(slot);
				if (!e[F_COMMIT]) break;
				nxt_off = slot + e[12:0] + 1;
				nxt_ok = 0;
				nxt = 0;
				if (!(slot <= wr_top && nxt_off >= wr_top) && nxt_off <= usable &&
				    nxt_off < MAX_UNITS) begin
					nxt_ok = 1;
					ne = tab_rd(nxt_off);
					nxt = ne[F_WRAP] ? 0 : nxt_off;
				end
				wr_bot = (nxt_ok && nxt == 0) ? 0 : (nxt_off & 13'h1FFF);
				count++;
				// Walked all the way round: the write window collapses onto the reader.
				if (nxt_ok && slot < start && nxt >= start) begin
					wr_bot = rd_top;
					wr_top = wr_bot;
					break;
				end
				have = nxt_ok;
				slot = nxt;
			end
		end
		if (count > 0) walks++;
		o.count = count[12:0];
		return o;
	endfunction

	function automatic outcome_t sync_reader(int unsigned rb, int unsigned rt);
		outcome_t    o;
		int unsigned u;
		o = '0;
		u = eff_units();
		o.status = ST_REJECTED;
		if (rb > u || rt > u) return o;
		if (rb == 0 && rt == 0) begin
			rb = rd_bot;
			rt = rd_top;
		end
		if (between_open(rb, wr_bot, wr_top) || between_open(rt, wr_bot, wr_top) ||
		    rd_top != rt || (rd_top < wr_bot && rt > wr_bot)) return o;
		rd_bot = rb;
		if (wr_top == rd_bot) begin
			rb = 0;
			wr_bot = 0;
			wr_top = 0;
		end
		rd_top = wr_bot;
		rd_bot = rb;
		o.status = ST_OK;
		o.gbot = rb[12:0];
		o.gtop = rd_top[12:0];
		o.resv = resv_cnt;
		o.drops = drop_cnt;
		resv_cnt = 0;
		drop_cnt = 0;
		good_syncs++;
		return o;
	endfunction

	function automatic outcome_t predict(logic [1:0] act, int unsigned bytes, int unsigned coff,
	                                     int unsigned rb, int unsigned rt);
		outcome_t o;
		o = '0;
		case (act)
			ACT_RESERVE: o = reserve_space(bytes);
			ACT_COMMIT:  o = commit_slot(coff);
			ACT_SYNC:    o = sync_reader(rb, rt);
			default:     o = '0;
		endcase
		return o;
	endfunction

	// Random input gap, mostly short with the odd long one.
	task automatic idle_in();
		int unsigned r, n;
		r = $urandom_range(99);
		n = (r < 65) ? 0 : (r < 95) ? $urandom_range(3, 1) : $urandom_range(40, 10);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Offers one transaction; returns at the edge where it was taken.
	task automatic send(logic [1:0] act, logic [15:0] bytes, logic [12:0] coff,
	                    logic [12:0] rb, logic [12:0] rt, bit typed, outcome_t typed_exp);
		outcome_t o;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {1'b0, rt, rb, coff, bytes};
		do @(posedge clk); while (!s_axis_tready);
		o = predict(act, bytes, coff, rb, rt);
		outcome_q.push_back(typed ? typed_exp : o);
		if (act == ACT_RESERVE && o.status == ST_OK) open_slots.push_back(o.slot);
		sent++;
	endtask

	task automatic write_ring(logic [12:0] v);
		s_axis_tvalid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ring_cfg = v;
	endtask

	task automatic random_phase(int n);
		int unsigned r, u, idx, maxb;
		logic [1:0]  act;
		logic [15:0] bytes;
		logic [12:0] coff, rb, rt;
		for (int k = 0; k < n; k++) begin
			u = eff_units();
			maxb = 16 * u / 3;
			r = $urandom_range(99);
			bytes = 16'($urandom_range(maxb));
			coff = 13'($urandom_range(u));
			rb = 0;
			rt = 0;
			if (r < 45) begin
				act = ACT_RESERVE;
				if ($urandom_range(9) == 0) bytes = 16'($urandom);
			end else if (r < 78) begin
				act = ACT_COMMIT;
				if (open_slots.size() != 0 && $urandom_range(9) < 8) begin
					// Favour the oldest record so that commits often start a walk.
					idx = ($urandom_range(1)) ? 0 : $urandom_range(open_slots.size() - 1);
					coff = open_slots[idx];
					open_slots.delete(idx);
				end else if ($urandom_range(3) == 0) begin
					coff = 13'($urandom);
				end
			end else if (r < 95) begin
				act = ACT_SYNC;
				case ($urandom_range(3))
					0: begin rb = 0; rt = 0; end
					1: begin rb = 13'($urandom_range(u)); rt = 13'(rd_top); end
					2: begin rb = 13'(wr_top); rt = 13'(rd_top); end
					default: begin rb = 13'($urandom); rt = 13'($urandom); end
				endcase
			end else begin
				act = ACT_UNUSED;
				bytes = 16'($urandom);
				coff = 13'($urandom);
				rb = 13'($urandom);
				rt = 13'($urandom);
			end
			send(act, bytes, coff, rb, rt, 0, '0);
			idle_in();
		end
	endtask

	// Output side: random stalls, plus a long hold when one is requested.
	initial begin
		int unsigned run, r;
		bit          rdy;
		run = 0;
		rdy = 1;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else begin
				if (run == 0) begin
					r = $urandom_range(99);
					if (r < 55) begin
						rdy = 1;
						run = $urandom_range(30, 1);
					end else if (r < 95) begin
						rdy = 0;
						run = $urandom_range(3, 1);
					end else begin
						rdy = 0;
						run = $urandom_range(40, 10);
					end
				end
				run--;
				m_axis_tready <= rdy;
			end
		end
	end

	always @(posedge clk) begin
		outcome_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser;
			got.slot   = m_axis_tdata[12:0];
			got.count  = m_axis_tdata[25:13];
			got.gbot   = m_axis_tdata[38:26];
			got.gtop   = m_axis_tdata[51:39];
			got.resv   = m_axis_tdata[83:52];
			got.drops  = m_axis_tdata[115:84];
			received++;
			if (outcome_q.size() == 0) begin
				$error("Result transaction with nothing outstanding");
				errors++;
			end else begin
				want = outcome_q.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					errors++;
				end
				if (got.slot !== want.slot) begin
					$error("slot_offset: expected %0d, got %0d", want.slot, got.slot);
					errors++;
				end
				if (got.count !== want.count) begin
					$error("commit_count: expected %0d, got %0d", want.count, got.count);
					errors++;
				end
				if (got.gbot !== want.gbot) begin
					$error("granted_bottom: expected %0d, got %0d", want.gbot, got.gbot);
					errors++;
				end
				if (got.gtop !== want.gtop) begin
					$error("granted_top: expected %0d, got %0d", want.gtop, got.gtop);
					errors++;
				end
				if (got.resv !== want.resv) begin
					$error("reservations_seen: expected %0d, got %0d", want.resv, got.resv);
					errors++;
				end
				if (got.drops !== want.drops) begin
					$error("drops_seen: expected %0d, got %0d", want.drops, got.drops);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t        rows [$];
		outcome_t    te;
		logic [12:0] ring_steps [$];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ACT_RESERVE;
		errors = 0; cycles = 0; sent = 0; received = 0;
		ok_reserves = 0; walks = 0; good_syncs = 0; hold_cycles = 0;
		ring_cfg = MAX_UNITS;
		wr_bot = 0; wr_top = 0; rd_bot = 0; rd_top = 0; resv_cnt = 0; drop_cnt = 0;
		foreach (slot_tab[i]) slot_tab[i] = '0;

		rows = '{
			'{ACT_RESERVE, 16'd0,     13'd0,    13'd0,    13'd0,    1, ST_OK,       13'd0, 13'd0},
			'{ACT_RESERVE, 16'hFFFF,  13'd0,    13'd0,    13'd0,    1, ST_TOO_BIG,  13'd0, 13'd0},
			'{ACT_RESERVE, 16'd65520, 13'd0,    13'd0,    13'd0,    1, ST_TOO_BIG,  13'd0, 13'd0},
			'{ACT_RESERVE, 16'd16,    13'd0,    13'd0,    13'd0,    0, ST_OK,       13'd0, 13'd0},
			'{ACT_RESERVE, 16'd17,    13'd0,    13'd0,    13'd0,    0, ST_OK,       13'd0, 13'd0},
			'{ACT_COMMIT,  16'd0,     13'd1,    13'd0,    13'd0,    0, ST_OK,       13'd0, 13'd0},
			'{ACT_COMMIT,  16'd0,     13'd0,    13'd0,    13'd0,    0, ST_OK,       13'd0, 13'd0},
			'{ACT_COMMIT,  16'd0,     13'd4096, 13'd0,    13'd0,    1, ST_OK,       13'd0, 13'd0},
			'{ACT_COMMIT,  16'hFFFF,  13'h1FFF, 13'd0,    13'd0,    1, ST_OK,       13'd0, 13'd0},
			'{ACT_COMMIT,  16'd0,     13'd4095, 13'd0,    13'd0,    0, ST_OK,       13'd0, 13'd0},
			'{ACT_SYNC,    16'd0,     13'd0,    13'h1FFF, 13'd0,    1, ST_REJECTED, 13'd0, 13'd0},
			'{ACT_SYNC,    16'd0,     13'd0,    13'd0,    13'h1FFF, 1, ST_REJECTED, 13'd0, 13'd0},
			'{ACT_SYNC,    16'd0,     13'd0,    13'd0,    13'd0,    0, ST_OK,       13'd0, 13'd0},
			'{ACT_UNUSED,  16'hFFFF,  13'h1FFF, 13'h1FFF, 13'h1FFF, 1, ST_OK,       13'd0, 13'd0},
			'{ACT_RESERVE, 16'd1,     13'd0,    13'd0,    13'd0,    0, ST_OK,       13'd0, 13'd0},
			'{ACT_RESERVE, 16'd40000, 13'd0,    13'd0,    13'd0,    0, ST_OK,       13'd0, 13'd0},
			'{ACT_RESERVE, 16'd30000, 13'd0,    13'd0,    13'd0,    0, ST_OK,       13'd0, 13'd0},
			'{ACT_SYNC,    16'd0,     13'd0,    13'd4096, 13'd4096, 0, ST_OK,       13'd0, 13'd0},
			'{ACT_SYNC,    16'd0,     13'd0,    13'd0,    13'd0,    0, ST_OK,       13'd0, 13'd0}
		};
		ring_steps = '{13'd3, 13'd40, 13'h1FFF, 13'd0, 13'd100, 13'd17, 13'd4096};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_ring(13'd4096);

		foreach (rows[i]) begin
			te = '0;
			te.status = rows[i].st;
			te.slot = rows[i].slot;
			te.count = rows[i].cnt;
			send(rows[i].act, rows[i].bytes, rows[i].coff, rows[i].rb, rows[i].rt,
			     rows[i].typed, te);
			idle_in();
		end
		random_phase(60);

		foreach (ring_steps[i]) begin
			write_ring(ring_steps[i]);
			// With the output held, the block fills and must stall its input.
			if (i == 1) hold_cycles = 400;
			random_phase(80);
		end
		s_axis_tvalid <= 1'b0;

		while (outcome_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("Sent %0d transactions over %0d ring sizes, %0d results checked.",
		         sent, ring_steps.size() + 1, received);
		$display("Reservations granted %0d, commit walks %0d, syncs accepted %0d.",
		         ok_reserves, walks, good_syncs);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
